/* rtl/fsts_pkg.sv */
// ----------------------------------------------------------------------------
// fsts_pkg
// Types, codes and geometry constants shared by the floppy sector transfer
// sequencer modules.
// ----------------------------------------------------------------------------
package fsts_pkg;

  // disk geometry
  localparam int SECTORS_PER_TRACK = 26;
  localparam int CHUNKS_PER_BLOCK  = 4;

  // field widths
  localparam int BLOCK_W  = 16;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 8;
  localparam int RETRY_W  = 4;
  localparam int EVENT_W  = 3;
  localparam int UNIT_W   = 8;
  localparam int TRACK_W  = 14;
  localparam int SECTOR_W = 5;
  localparam int OFFSET_W = 17;
  localparam int DONE_W   = 10;
  localparam int CFG_W    = 16;

  // derived sizes
  localparam int CHUNK_W  = (CHUNKS_PER_BLOCK > 1) ? $clog2(CHUNKS_PER_BLOCK) : 1;
  localparam int LIN_W    = BLOCK_W + CHUNK_W;
  localparam int SEC_W    = $clog2(SECTORS_PER_TRACK);
  localparam int QUOT_W   = LIN_W - 3;
  localparam int SHIFT_W  = OFFSET_W - DONE_W;

  // reciprocal for the division of the linear sector by the track length
  localparam int RECIP_K   = LIN_W + 6;
  localparam int RECIP_W   = RECIP_K + 1;
  localparam int PROD_W    = BLOCK_W + RECIP_W;
  localparam longint RECIP = ((64'd1 << RECIP_K) + SECTORS_PER_TRACK - 1) / SECTORS_PER_TRACK;
  localparam logic [RECIP_W-1:0] RECIP_BLK = RECIP_W'(RECIP * CHUNKS_PER_BLOCK);

  localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(CHUNKS_PER_BLOCK - 1);
  localparam logic [SEC_W-1:0]   SEC_LAST   = SEC_W'(SECTORS_PER_TRACK - 1);

  // controller and command word codes
  localparam logic [STATUS_W-1:0] STAT_FAULT  = 8'h40;
  localparam logic [STATUS_W-1:0] STAT_CRC    = 8'h08;
  localparam logic [UNIT_W-1:0]   UNIT_DRIVE0 = 8'd129;
  localparam logic [UNIT_W-1:0]   UNIT_DRIVE1 = 8'd130;
  localparam logic [COUNT_W-1:0]  MAX_COUNT   = 11'd1024;

  // register reset values
  localparam logic [BLOCK_W-1:0] BLOCK_LIMIT_RST = 16'd500;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd10;

  typedef enum logic [0:0] {
    REG_BLOCK_LIMIT = 1'b0,
    REG_RETRY_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_ISSUE    = 3'd0,
    EV_RETRY    = 3'd1,
    EV_DONE_OK  = 3'd2,
    EV_DONE_ERR = 3'd3,
    EV_REJECT   = 3'd4,
    EV_IGNORE   = 3'd5
  } event_t;

  typedef enum logic [0:0] {
    CMD_REQUEST  = 1'b0,
    CMD_COMPLETE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                cmd;
    logic                drive;
    logic [BLOCK_W-1:0]  block;
    logic                is_read;
    logic [COUNT_W-1:0]  sector_count;
    logic [STATUS_W-1:0] status;
  } req_t;

  typedef struct packed {
    logic [EVENT_W-1:0]  event_res;
    logic [UNIT_W-1:0]   unit_code;
    logic [TRACK_W-1:0]  track;
    logic [SECTOR_W-1:0] sector;
    logic                is_write;
    logic [OFFSET_W-1:0] buffer_offset;
  } res_t;

  // request beat with the track of its first sector
  typedef struct packed {
    req_t               item;
    logic [QUOT_W-1:0]  quot;
  } located_t;

endpackage

/* rtl/fsts_locate.sv */
// ----------------------------------------------------------------------------
// fsts_locate
// Input register and reciprocal multiply stage: finds the starting track of
// a request's first sector.
// ----------------------------------------------------------------------------
module fsts_locate import fsts_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  req_t     req,
  output logic     loc_valid,
  input  logic     loc_ready,
  output located_t loc
);

  logic              in_valid;
  req_t              in_item;
  logic              in_load;
  logic              loc_load;
  logic [PROD_W-1:0] prod;

  assign loc_load  = in_valid && (!loc_valid || loc_ready);
  assign req_stall = in_valid && !(!loc_valid || loc_ready);
  assign in_load   = req_valid && !req_stall;

  // block * chunks * reciprocal, quotient taken from the high bits
  assign prod = PROD_W'(in_item.block) * PROD_W'(RECIP_BLK);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      loc_valid <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid <= 1'b1;
      end else if (loc_load) begin
        in_valid <= 1'b0;
      end
      if (loc_load) begin
        loc_valid <= 1'b1;
      end else if (loc_ready) begin
        loc_valid <= 1'b0;
      end
    end
    if (in_load) begin
      in_item <= req;
    end
    if (loc_load) begin
      loc.item <= in_item;
      loc.quot <= prod[RECIP_K +: QUOT_W];
    end
  end

endmodule

/* rtl/fsts_seq.sv */
// ----------------------------------------------------------------------------
// fsts_seq
// Transfer state, retry handling and the result register.
// ----------------------------------------------------------------------------
module fsts_seq import fsts_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_en,
  input  logic [0:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               loc_valid,
  output logic               loc_ready,
  input  located_t           loc,
  output logic               res_valid,
  input  logic               res_stall,
  output res_t               res
);

  logic [BLOCK_W-1:0] block_limit;
  logic [RETRY_W-1:0] retry_limit;

  logic               busy,           busy_next;
  logic               cur_drive,      cur_drive_next;
  logic [BLOCK_W-1:0] cur_block,      cur_block_next;
  logic               cur_read,       cur_read_next;
  logic [COUNT_W-1:0] sectors_left,   sectors_left_next;
  logic [CHUNK_W-1:0] chunk_in_block, chunk_in_block_next;
  logic [RETRY_W-1:0] retry_count,    retry_count_next;
  logic               error_seen,     error_seen_next;
  logic [DONE_W-1:0]  sectors_done,   sectors_done_next;
  logic [TRACK_W-1:0] trk,            trk_next;
  logic [SEC_W-1:0]   sec_idx,        sec_idx_next;
  res_t               res_next;

  logic               fire;
  logic [LIN_W-1:0]   lin_req;
  logic [LIN_W-1:0]   rem;
  logic               fault;
  logic [COUNT_W-1:0] left_dec;
  req_t               it;

  function automatic res_t sector_beat(input event_t ev, input logic drv,
                                       input logic [TRACK_W-1:0] t,
                                       input logic [SEC_W-1:0] s, input logic rd,
                                       input logic [DONE_W-1:0] done);
    res_t r;
    r.event_res     = ev;
    r.unit_code     = drv ? UNIT_DRIVE1 : UNIT_DRIVE0;
    r.track         = t;
    r.sector        = SECTOR_W'({1'b0, s} + 1'b1);
    r.is_write      = !rd;
    r.buffer_offset = {done, {SHIFT_W{1'b0}}};
    return r;
  endfunction

  function automatic res_t plain_beat(input event_t ev);
    res_t r;
    r           = '0;
    r.event_res = ev;
    return r;
  endfunction

  assign it        = loc.item;
  assign loc_ready = !res_valid || !res_stall;
  assign fire      = loc_valid && loc_ready;
  assign lin_req   = LIN_W'(it.block) * LIN_W'(CHUNKS_PER_BLOCK);
  assign rem       = lin_req - LIN_W'(loc.quot) * LIN_W'(SECTORS_PER_TRACK);
  assign fault     = (it.status & (STAT_FAULT | STAT_CRC)) != '0;
  assign left_dec  = sectors_left - 1'b1;

  always_comb begin
    busy_next           = busy;
    cur_drive_next      = cur_drive;
    cur_block_next      = cur_block;
    cur_read_next       = cur_read;
    sectors_left_next   = sectors_left;
    chunk_in_block_next = chunk_in_block;
    retry_count_next    = retry_count;
    error_seen_next     = error_seen;
    sectors_done_next   = sectors_done;
    trk_next            = trk;
    sec_idx_next        = sec_idx;
    res_next            = plain_beat(EV_IGNORE);

    if (it.cmd == CMD_REQUEST) begin
      if (it.block >= block_limit) begin
        res_next = plain_beat(EV_REJECT);
      end else if (busy) begin
        res_next = plain_beat(EV_IGNORE);
      end else if (it.sector_count == '0) begin
        res_next = plain_beat(EV_DONE_OK);
      end else begin
        busy_next           = 1'b1;
        cur_drive_next      = it.drive;
        cur_block_next      = it.block;
        cur_read_next       = it.is_read;
        sectors_left_next   = (it.sector_count > MAX_COUNT) ? MAX_COUNT : it.sector_count;
        chunk_in_block_next = '0;
        retry_count_next    = '0;
        error_seen_next     = 1'b0;
        sectors_done_next   = '0;
        trk_next            = loc.quot[TRACK_W-1:0];
        sec_idx_next        = rem[SEC_W-1:0];
        res_next = sector_beat(EV_ISSUE, it.drive, loc.quot[TRACK_W-1:0],
                               rem[SEC_W-1:0], it.is_read, '0);
      end
    end else if (!busy) begin
      res_next = plain_beat(EV_IGNORE);
    end else if (fault && (retry_count < retry_limit)) begin
      retry_count_next = retry_count + 1'b1;
      res_next = sector_beat(EV_RETRY, cur_drive, trk, sec_idx, cur_read, sectors_done);
    end else begin
      error_seen_next   = error_seen | fault;
      retry_count_next  = '0;
      sectors_left_next = left_dec;
      if (left_dec == '0) begin
        busy_next           = 1'b0;
        chunk_in_block_next = '0;
        res_next = plain_beat((error_seen | fault) ? EV_DONE_ERR : EV_DONE_OK);
      end else begin
        // next sector: linear position steps by one, back to zero on block wrap
        if (chunk_in_block == CHUNK_LAST) begin
          chunk_in_block_next = '0;
          cur_block_next      = cur_block + 1'b1;
        end else begin
          chunk_in_block_next = chunk_in_block + 1'b1;
        end
        if ((chunk_in_block == CHUNK_LAST) && (cur_block == '1)) begin
          trk_next     = '0;
          sec_idx_next = '0;
        end else if (sec_idx == SEC_LAST) begin
          trk_next     = trk + 1'b1;
          sec_idx_next = '0;
        end else begin
          sec_idx_next = sec_idx + 1'b1;
        end
        sectors_done_next = sectors_done + 1'b1;
        res_next = sector_beat(EV_ISSUE, cur_drive, trk_next, sec_idx_next, cur_read,
                               sectors_done_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_limit    <= BLOCK_LIMIT_RST;
      retry_limit    <= RETRY_LIMIT_RST;
      busy           <= 1'b0;
      cur_drive      <= 1'b0;
      cur_block      <= '0;
      cur_read       <= 1'b0;
      sectors_left   <= '0;
      chunk_in_block <= '0;
      retry_count    <= '0;
      error_seen     <= 1'b0;
      sectors_done   <= '0;
      trk            <= '0;
      sec_idx        <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          REG_BLOCK_LIMIT: block_limit <= cfg_data;
          REG_RETRY_LIMIT: retry_limit <= cfg_data[RETRY_W-1:0];
          default: ;
        endcase
      end
      if (fire) begin
        busy           <= busy_next;
        cur_drive      <= cur_drive_next;
        cur_block      <= cur_block_next;
        cur_read       <= cur_read_next;
        sectors_left   <= sectors_left_next;
        chunk_in_block <= chunk_in_block_next;
        retry_count    <= retry_count_next;
        error_seen     <= error_seen_next;
        sectors_done   <= sectors_done_next;
        trk            <= trk_next;
        sec_idx        <= sec_idx_next;
        res_valid      <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
    if (fire) begin
      res <= res_next;
    end
  end

endmodule

/* rtl/floppy_sector_transfer_sequencer.sv */
// ----------------------------------------------------------------------------
// floppy_sector_transfer_sequencer
// Splits block transfer requests into sector commands and steps through them
// on controller completions, with retries on fault or CRC status.
//
//   channel  dir  handshake            beat
//   req      in   req_valid/req_stall  request or completion status
//   res      out  res_valid/res_stall  one event per accepted beat
//   cfg      in   cfg_en               block_limit, retry_limit writes
//
// one beat accepted per cycle while the result is not stalled; a result passes
// the input register, the track multiply register and the result register
// the track of a new request comes from one reciprocal multiply; later sectors
// step the track and sector counters, so each beat is a single state update
// synchronous reset clears the transfer state and loads the register defaults
// a stalled result holds the pipeline and raises req_stall once it is full
// ----------------------------------------------------------------------------
module floppy_sector_transfer_sequencer import fsts_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_en,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             res_valid,
  input  logic             res_stall,
  output res_t             res
);

  logic     loc_valid;
  logic     loc_ready;
  located_t loc;

  fsts_locate u_locate (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .loc_valid (loc_valid),
    .loc_ready (loc_ready),
    .loc       (loc)
  );

  fsts_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .loc_valid (loc_valid),
    .loc_ready (loc_ready),
    .loc       (loc),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

/* sim/floppy_sector_transfer_sequencer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// floppy_sector_transfer_sequencer_tb
// Self-checking bench for the sector transfer sequencer. Request and
// completion beats go in under random idling on both channels, and every beat
// is run through a cycle-free model of the transfer state in the bench. Each
// result beat is checked field by field against the oldest predicted event.
// The run covers reject, ignore, clamp, retry exhaustion and block wrap cases,
// one long transfer, a stretch of output back-pressure and several limits.
// ----------------------------------------------------------------------------
module floppy_sector_transfer_sequencer_tb;
  import fsts_pkg::*;

  localparam int  SECTOR_BYTES = 128;
  localparam real RUN_LIMIT_NS = 10_000_000.0;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_en = 1'b0;
  cfg_reg_t         cfg_index = REG_BLOCK_LIMIT;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_t             req = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  res_t             res;

  // bench copy of the transfer state and limits
  logic [BLOCK_W-1:0]  lim_block = BLOCK_LIMIT_RST;
  logic [RETRY_W-1:0]  lim_retry = RETRY_LIMIT_RST;
  logic                xfer_busy = 1'b0;
  logic                xfer_drive = 1'b0;
  logic [BLOCK_W-1:0]  xfer_block = '0;
  logic                xfer_read = 1'b0;
  logic [COUNT_W-1:0]  xfer_left = '0;
  logic [CHUNK_W-1:0]  xfer_chunk = '0;
  logic [RETRY_W-1:0]  xfer_retries = '0;
  logic                had_error = 1'b0;
  logic [DONE_W-1:0]   xfer_done = '0;

  res_t events_due[$];
  int   mismatches = 0;
  bit   idle_en = 1'b1;
  int   stall_hold = 0;
  int   stall_burst = 0;

  floppy_sector_transfer_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #10 clk = ~clk;

  function automatic res_t plain_word(event_t ev);
    res_t w;
    w = '0;
    w.event_res = ev;
    return w;
  endfunction

  function automatic res_t sector_word(event_t ev);
    int unsigned lin;
    res_t w;
    lin = xfer_block * CHUNKS_PER_BLOCK + xfer_chunk;
    w.event_res     = ev;
    w.unit_code     = xfer_drive ? UNIT_DRIVE1 : UNIT_DRIVE0;
    w.track         = TRACK_W'(lin / SECTORS_PER_TRACK);
    w.sector        = SECTOR_W'(lin % SECTORS_PER_TRACK + 1);
    w.is_write      = ~xfer_read;
    w.buffer_offset = OFFSET_W'(xfer_done * SECTOR_BYTES);
    return w;
  endfunction

  // advance the bench state by one accepted beat and queue its event
  task automatic advance_transfer(req_t b);
    logic faulty;
    res_t w;
    faulty = (b.status & (STAT_FAULT | STAT_CRC)) != '0;
    if (b.cmd == CMD_REQUEST) begin
      if (b.block >= lim_block) begin
        w = plain_word(EV_REJECT);
      end else if (xfer_busy) begin
        w = plain_word(EV_IGNORE);
      end else if (b.sector_count == '0) begin
        w = plain_word(EV_DONE_OK);
      end else begin
        xfer_busy    = 1'b1;
        xfer_drive   = b.drive;
        xfer_block   = b.block;
        xfer_read    = b.is_read;
        xfer_left    = (b.sector_count > MAX_COUNT) ? MAX_COUNT : b.sector_count;
        xfer_chunk   = '0;
        xfer_retries = '0;
        had_error    = 1'b0;
        xfer_done    = '0;
        w = sector_word(EV_ISSUE);
      end
    end else if (!xfer_busy) begin
      w = plain_word(EV_IGNORE);
    end else if (faulty && xfer_retries < lim_retry) begin
      xfer_retries = xfer_retries + 1'b1;
      w = sector_word(EV_RETRY);
    end else begin
      if (faulty) had_error = 1'b1;
      xfer_retries = '0;
      xfer_left = xfer_left - 1'b1;
      if (xfer_left == '0) begin
        xfer_busy  = 1'b0;
        xfer_chunk = '0;
        w = plain_word(had_error ? EV_DONE_ERR : EV_DONE_OK);
      end else begin
        if (xfer_chunk == CHUNK_LAST) begin
          xfer_chunk = '0;
          xfer_block = xfer_block + 1'b1;
        end else begin
          xfer_chunk = xfer_chunk + 1'b1;
        end
        xfer_done = xfer_done + 1'b1;
        w = sector_word(EV_ISSUE);
      end
    end
    events_due.push_back(w);
  endtask

  function automatic req_t noise_beat();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(req_t)-1:0];
  endfunction

  function automatic req_t request_beat(logic drv, logic [BLOCK_W-1:0] blk, logic rd,
                                        logic [COUNT_W-1:0] cnt);
    req_t b;
    b = noise_beat();
    b.cmd          = CMD_REQUEST;
    b.drive        = drv;
    b.block        = blk;
    b.is_read      = rd;
    b.sector_count = cnt;
    return b;
  endfunction

  function automatic req_t status_beat(logic [STATUS_W-1:0] st);
    req_t b;
    b = noise_beat();
    b.cmd    = CMD_COMPLETE;
    b.status = st;
    return b;
  endfunction

  // random status byte, fault or crc bits kept in about pct percent of beats
  function automatic logic [STATUS_W-1:0] rand_status(int pct);
    logic [STATUS_W-1:0] st;
    st = STATUS_W'($urandom);
    if ($urandom_range(0, 99) >= pct) st = st & ~(STAT_FAULT | STAT_CRC);
    return st;
  endfunction

  task automatic send_beat(req_t b);
    req <= b;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    advance_transfer(b);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (events_due.size() != 0);
  endtask

  task automatic write_limits(logic [BLOCK_W-1:0] blk, logic [RETRY_W-1:0] rty);
    wait_drained();
    cfg_en    <= 1'b1;
    cfg_index <= REG_BLOCK_LIMIT;
    cfg_data  <= blk;
    @(posedge clk);
    cfg_index <= REG_RETRY_LIMIT;
    cfg_data  <= CFG_W'(rty);
    @(posedge clk);
    cfg_en <= 1'b0;
    @(posedge clk);
    lim_block = blk;
    lim_retry = rty;
  endtask

  // mostly well-formed transfers, with stray requests and completions mixed in
  task automatic send_random_beats(int n);
    bit stray;
    bit want_req;
    int pick;
    logic [BLOCK_W-1:0] blk;
    logic [COUNT_W-1:0] cnt;
    for (int i = 0; i < n; i++) begin
      stray    = $urandom_range(0, 9) == 0;
      want_req = xfer_busy ? stray : !stray;
      if (want_req) begin
        if ($urandom_range(0, 7) == 0) blk = BLOCK_W'($urandom);
        else blk = BLOCK_W'($urandom_range(0, lim_block - 1));
        pick = $urandom_range(0, 19);
        if (pick == 0) cnt = '0;
        else if (pick < 3) cnt = COUNT_W'($urandom_range(13, 60));
        else cnt = COUNT_W'($urandom_range(1, 12));
        send_beat(request_beat(1'($urandom_range(0, 1)), blk, 1'($urandom_range(0, 1)),
                               cnt));
      end else begin
        send_beat(status_beat(rand_status(25)));
      end
    end
  endtask

  task automatic test_directed_corners();
    send_beat(status_beat(8'h00));
    send_beat(request_beat(1'b0, 16'd500, 1'b1, 11'd4));
    send_beat(request_beat(1'b1, 16'hFFFF, 1'b0, 11'd4));
    send_beat(request_beat(1'b0, 16'd0, 1'b1, 11'd0));
    send_beat(request_beat(1'b1, 16'd499, 1'b0, 11'd5));
    send_beat(status_beat(STAT_FAULT));
    send_beat(status_beat(STAT_CRC));
    send_beat(request_beat(1'b0, 16'd0, 1'b1, 11'd1));
    send_beat(status_beat(8'hB7));
    send_beat(status_beat(8'hFF));
    repeat (4) send_beat(status_beat(8'h00));
    send_beat(status_beat(8'h00));
  endtask

  task automatic test_retry_exhaust();
    write_limits(16'd500, 4'd15);
    send_beat(request_beat(1'b0, 16'd1, 1'b1, 11'd2));
    repeat (16) send_beat(status_beat(STAT_FAULT | STAT_CRC));
    send_beat(status_beat(8'h00));
  endtask

  // block number rolls over mid transfer; no retries allowed
  task automatic test_block_wrap_zero_retry();
    write_limits(16'hFFFF, 4'd0);
    send_beat(request_beat(1'b1, 16'hFFFF, 1'b1, 11'd3));
    send_beat(request_beat(1'b1, 16'hFFFE, 1'b1, 11'd12));
    send_beat(status_beat(STAT_FAULT));
    while (xfer_busy) send_beat(status_beat(rand_status(30)));
  endtask

  // count above the cap; walks the buffer offset through its whole range
  task automatic test_clamped_long_transfer();
    write_limits(16'd500, 4'd3);
    send_beat(request_beat(1'b1, 16'd123, 1'b0, 11'h7FF));
    while (xfer_busy) send_beat(status_beat(rand_status(2)));
  endtask

  task automatic test_backpressure_fill();
    stall_hold = 200;
    send_random_beats(24);
  endtask

  task automatic test_drain_pause();
    send_random_beats(10);
    wait_drained();
    send_random_beats(10);
  endtask

  task automatic test_random_phases();
    write_limits(BLOCK_LIMIT_RST, RETRY_LIMIT_RST);
    send_random_beats(8);
    write_limits(16'd1, 4'd0);
    send_random_beats(8);
    write_limits(16'hFFFF, 4'hF);
    send_random_beats(8);
    write_limits(BLOCK_W'($urandom_range(1, 65535)), RETRY_W'($urandom_range(0, 15)));
    send_random_beats(8);
    idle_en = 1'b0;
    write_limits(BLOCK_W'($urandom_range(1, 65535)), RETRY_W'($urandom_range(0, 15)));
    send_random_beats(8);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_corners();
    test_retry_exhaust();
    test_block_wrap_zero_retry();
    test_clamped_long_transfer();
    test_backpressure_fill();
    test_drain_pause();
    test_random_phases();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // output side stalls, plus the long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (stall_hold > 0) begin
        res_stall <= 1'b1;
        stall_hold--;
      end else if (stall_burst > 0) begin
        res_stall <= 1'b1;
        stall_burst--;
      end else begin
        res_stall <= 1'b0;
        if (idle_en && $urandom_range(0, 5) == 0) stall_burst = $urandom_range(1, 19);
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (events_due.size() == 0) begin
        $display("%0t ns: result beat expected none actual event %0d", $time, res.event_res);
        mismatches++;
      end else begin
        want = events_due.pop_front();
        check_field("event_res", want.event_res, res.event_res);
        check_field("unit_code", want.unit_code, res.unit_code);
        check_field("track", want.track, res.track);
        check_field("sector", want.sector, res.sector);
        check_field("is_write", want.is_write, res.is_write);
        check_field("buffer_offset", want.buffer_offset, res.buffer_offset);
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

endmodule
